FILE: design/tvac_pkg.sv
// shared constants and tables for the thrust vector to actuator command block
package tvac_pkg;

  localparam int CORDIC_STAGES_DEF = 16;
  localparam int ATAN_LEN = 24;

  // square root unit: 48-bit radicand, 24-bit root, one root bit a stage
  localparam int SQ_W = 48;
  localparam int SQ_R = SQ_W / 2;

  // quotient bits of the ratio divider, plus its input and output stages
  localparam int DIV_Q = 16;
  localparam int DIV_LAT = DIV_Q + 2;

  localparam int ANG_W = 28;
  localparam int CX_W = 43;
  localparam int CIN_W = 25;

  localparam logic signed [ANG_W-1:0] PI_Q24 = 28'sd52707179;
  localparam logic [15:0] GIMBAL_SAT = 16'd32767;

  localparam logic [1:0] CFG_THRUST_LIMIT = 2'd0;
  localparam logic [1:0] CFG_THROTTLE_SCALE = 2'd1;
  localparam logic [1:0] CFG_MAX_DEFLECTION = 2'd2;

  localparam logic [22:0] THRUST_LIMIT_RST = 23'd925788;
  localparam logic [15:0] THROTTLE_SCALE_RST = 16'd17490;
  localparam logic [16:0] MAX_DEFLECTION_RST = 17'd17157;

  localparam logic signed [ANG_W-1:0] ATAN_Q24 [ATAN_LEN] = '{
    28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331,
    28'sd1047214, 28'sd524117, 28'sd262123, 28'sd131069,
    28'sd65536, 28'sd32768, 28'sd16384, 28'sd8192,
    28'sd4096, 28'sd2048, 28'sd1024, 28'sd512,
    28'sd256, 28'sd128, 28'sd64, 28'sd32,
    28'sd16, 28'sd8, 28'sd4, 28'sd2
  };

endpackage

FILE: design/thrust_vector_to_actuator_cmds_top.sv
// thrust vector to throttle and gimbal deflection pipeline, top level
//
// input channel in_*: one thrust vector (x, y, z, signed q8.16 newtons) per
// request, taken when in_valid is high and in_stall is low. result channel
// out_*: one throttle (q1.15), two gimbal deflections (signed q1.15) and a
// saturation flag per request, in order.
// the pipeline runs through two square root chains of 24 stages, the
// cordic stages and an 18-stage divider. one request can enter every
// cycle while in_stall is low; the pipeline has no feedback between items.
// the final pipeline stage is the output register. when out_stall is high
// with a result waiting, the whole pipeline holds and in_stall rises in the
// same cycle; nothing is lost or repeated.
// cfg_we writes register cfg_index (0 thrust limit, 1 throttle scale,
// 2 max deflection); an unknown index is ignored. write only while idle.
// synchronous reset (rst_n low) empties the pipeline and loads the
// register defaults.
module thrust_vector_to_actuator_cmds_top import tvac_pkg::*; #(
  parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [23:0] in_thrust_x,
  input  logic signed [23:0] in_thrust_y,
  input  logic signed [23:0] in_thrust_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [15:0]        out_throttle,
  output logic signed [15:0] out_gimbal_axis0,
  output logic signed [15:0] out_gimbal_axis1,
  output logic               out_thrust_saturated,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [22:0]        cfg_data
);

  localparam int LAT = 2 + SQ_R + 3 + SQ_R + 1 + (CORDIC_STAGES + 1) + DIV_LAT;

  logic        en;
  logic [LAT-1:0] vld_r;

  logic [22:0] thrust_limit_r;
  logic [15:0] throttle_scale_r;
  logic [16:0] max_deflection_r;
  logic [45:0] lim_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thrust_limit_r   <= THRUST_LIMIT_RST;
      throttle_scale_r <= THROTTLE_SCALE_RST;
      max_deflection_r <= MAX_DEFLECTION_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_THRUST_LIMIT:   thrust_limit_r   <= cfg_data;
        CFG_THROTTLE_SCALE: throttle_scale_r <= cfg_data[15:0];
        CFG_MAX_DEFLECTION: max_deflection_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    lim_sq_r <= thrust_limit_r * thrust_limit_r;
  end

  // global pipeline enable: hold everything while a result waits
  assign en       = !(vld_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end
  assign out_valid = vld_r[LAT-1];

  // squares and sum of squares
  logic signed [23:0] x1_r, y1_r, z1_r;
  logic [46:0]        ax2_r, ay2_r, az2_r;
  logic [22:0]        axa, aya, aza;
  logic signed [23:0] x2_r, y2_r, z2_r;
  logic [46:0]        x2sq_r;
  logic [47:0]        sumsq_r;
  logic               sat2_r;

  always_comb begin
    axa = in_thrust_x[23] ? 23'(-in_thrust_x) : in_thrust_x[22:0];
    aya = in_thrust_y[23] ? 23'(-in_thrust_y) : in_thrust_y[22:0];
    aza = in_thrust_z[23] ? 23'(-in_thrust_z) : in_thrust_z[22:0];
  end

  // the most negative value has magnitude 2^23, which 23 bits cannot hold
  logic [23:0] axf, ayf, azf;
  assign axf = (in_thrust_x == 24'sh800000) ? 24'h800000 : {1'b0, axa};
  assign ayf = (in_thrust_y == 24'sh800000) ? 24'h800000 : {1'b0, aya};
  assign azf = (in_thrust_z == 24'sh800000) ? 24'h800000 : {1'b0, aza};

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r  <= in_thrust_x;
      y1_r  <= in_thrust_y;
      z1_r  <= in_thrust_z;
      ax2_r <= 47'(axf * axf);
      ay2_r <= 47'(ayf * ayf);
      az2_r <= 47'(azf * azf);
    end
  end

  logic [47:0] sumsq;
  assign sumsq = 48'(ax2_r) + 48'(ay2_r) + 48'(az2_r);

  always_ff @(posedge clk) begin
    if (en) begin
      x2_r    <= x1_r;
      y2_r    <= y1_r;
      z2_r    <= z1_r;
      x2sq_r  <= ax2_r;
      sumsq_r <= sumsq;
      sat2_r  <= sumsq > 48'(lim_sq_r);
    end
  end

  // magnitude
  logic [SQ_R-1:0] mag_root;
  logic [24*3+47:0] side_a_d, side_a_q;

  tvac_isqrt u_sqrt_mag (
    .clk  (clk),
    .en   (en),
    .rad  (sumsq_r),
    .root (mag_root)
  );

  assign side_a_d = {sat2_r, x2_r, y2_r, z2_r, x2sq_r};

  tvac_dly #(.W(24*3+48), .N(SQ_R)) u_dly_a (
    .clk (clk),
    .en  (en),
    .d   (side_a_d),
    .q   (side_a_q)
  );

  logic               sat3_r, sat4_r, sat5_r;
  logic signed [23:0] x3_r, y3_r, z3_r, x4_r, y4_r, z4_r, x5_r, y5_r, z5_r;
  logic [46:0]        x3sq_r, x4sq_r;
  logic [23:0]        mag3_r, mag4_r, mag5_r;
  logic [47:0]        m2_r;
  logic [47:0]        csq_r;
  logic               mz5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      {sat3_r, x3_r, y3_r, z3_r, x3sq_r} <= side_a_q;
      mag3_r <= side_a_q[24*3+47] ? {1'b0, thrust_limit_r} : mag_root;

      sat4_r <= sat3_r;
      x4_r   <= x3_r;
      y4_r   <= y3_r;
      z4_r   <= z3_r;
      x4sq_r <= x3sq_r;
      mag4_r <= mag3_r;
      m2_r   <= mag3_r * mag3_r;

      sat5_r <= sat4_r;
      x5_r   <= x4_r;
      y5_r   <= y4_r;
      z5_r   <= z4_r;
      mag5_r <= mag4_r;
      mz5_r  <= (mag4_r == '0);
      csq_r  <= (m2_r > 48'(x4sq_r)) ? m2_r - 48'(x4sq_r) : '0;
    end
  end

  // cosine leg for the asin and the root for the throttle
  logic [SQ_R-1:0] c_root, s_root;
  logic [24*3+1:0] side_b_d, side_b_q;

  tvac_isqrt u_sqrt_cos (
    .clk  (clk),
    .en   (en),
    .rad  (csq_r),
    .root (c_root)
  );

  tvac_isqrt u_sqrt_thr (
    .clk  (clk),
    .en   (en),
    .rad  ({8'h00, mag5_r, 16'h0000}),
    .root (s_root)
  );

  assign side_b_d = {sat5_r, mz5_r, x5_r, y5_r, z5_r};

  tvac_dly #(.W(24*3+2), .N(SQ_R)) u_dly_b (
    .clk (clk),
    .en  (en),
    .d   (side_b_d),
    .q   (side_b_q)
  );

  logic               sat6_r, mz6_r;
  logic signed [23:0] x6_r, y6_r, z6_r;
  logic [SQ_R-1:0]    c6_r;
  logic [15:0]        thr6_r;
  logic [39:0]        thr_prod;

  assign thr_prod = 40'(s_root) * 40'(throttle_scale_r);

  always_ff @(posedge clk) begin
    if (en) begin
      {sat6_r, mz6_r, x6_r, y6_r, z6_r} <= side_b_q;
      c6_r   <= c_root;
      thr6_r <= (thr_prod[39:33] != '0) ? 16'hFFFF : thr_prod[32:17];
    end
  end

  // angles
  logic signed [ANG_W-1:0] ang0, ang1;
  logic [17:0]             side_c_q;
  logic [16:0]             side_d_q;
  logic                    mz_c;

  tvac_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_g0 (
    .clk (clk),
    .en  (en),
    .yi  (-{y6_r[23], y6_r}),
    .xi  ({z6_r[23], z6_r}),
    .ang (ang0)
  );

  tvac_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_g1 (
    .clk (clk),
    .en  (en),
    .yi  ({x6_r[23], x6_r}),
    .xi  ({1'b0, c6_r}),
    .ang (ang1)
  );

  tvac_dly #(.W(18), .N(CORDIC_STAGES + 1)) u_dly_c (
    .clk (clk),
    .en  (en),
    .d   ({sat6_r, mz6_r, thr6_r}),
    .q   (side_c_q)
  );

  assign mz_c = side_c_q[16];

  tvac_div u_div_g0 (
    .clk   (clk),
    .en    (en),
    .ang   (ang0),
    .dvs   (max_deflection_r),
    .ratio (out_gimbal_axis0)
  );

  // zero magnitude gives no tilt on the second axis
  tvac_div u_div_g1 (
    .clk   (clk),
    .en    (en),
    .ang   (mz_c ? '0 : ang1),
    .dvs   (max_deflection_r),
    .ratio (out_gimbal_axis1)
  );

  tvac_dly #(.W(17), .N(DIV_LAT)) u_dly_d (
    .clk (clk),
    .en  (en),
    .d   ({side_c_q[17], side_c_q[15:0]}),
    .q   (side_d_q)
  );

  assign out_thrust_saturated = side_d_q[16];
  assign out_throttle         = side_d_q[15:0];

endmodule

FILE: design/tvac_dly.sv
// delay line that carries side data alongside a pipelined unit
module tvac_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr_r [N];

  always_ff @(posedge clk) begin
    if (en) begin
      sr_r[0] <= d;
      for (int i = 1; i < N; i++) begin
        sr_r[i] <= sr_r[i-1];
      end
    end
  end

  assign q = sr_r[N-1];

endmodule

FILE: design/tvac_isqrt.sv
// pipelined integer square root, one root bit per stage
module tvac_isqrt import tvac_pkg::*; (
  input  logic            clk,
  input  logic            en,
  input  logic [SQ_W-1:0] rad,
  output logic [SQ_R-1:0] root
);

  // remainder can reach twice the partial root, so it keeps one extra bit
  logic [SQ_R:0]   rem_r  [1:SQ_R];
  logic [SQ_R-1:0] root_r [1:SQ_R];
  logic [SQ_W-1:0] v_r    [1:SQ_R];

  for (genvar i = 0; i < SQ_R; i++) begin : g_stage
    logic [SQ_R:0]   rem_i;
    logic [SQ_R-1:0] root_i;
    logic [SQ_W-1:0] v_i;
    logic [SQ_R+2:0] rs;
    logic [SQ_R+2:0] trial;
    logic            ge;

    if (i == 0) begin : g_head
      assign rem_i  = '0;
      assign root_i = '0;
      assign v_i    = rad;
    end else begin : g_body
      assign rem_i  = rem_r[i];
      assign root_i = root_r[i];
      assign v_i    = v_r[i];
    end

    always_comb begin
      rs    = {rem_i, v_i[SQ_W-1 -: 2]};
      trial = {1'b0, root_i, 2'b01};
      ge    = (rs >= trial);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[i+1]  <= ge ? (SQ_R+1)'(rs - trial) : (SQ_R+1)'(rs);
        root_r[i+1] <= {root_i[SQ_R-2:0], ge};
        v_r[i+1]    <= {v_i[SQ_W-3:0], 2'b00};
      end
    end
  end

  assign root = root_r[SQ_R];

endmodule

FILE: design/tvac_cordic.sv
// pipelined vectoring cordic, atan2(y, x) in q.24 radians
module tvac_cordic import tvac_pkg::*; #(
  parameter int STAGES = CORDIC_STAGES_DEF
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [CIN_W-1:0] yi,
  input  logic signed [CIN_W-1:0] xi,
  output logic signed [ANG_W-1:0] ang
);

  logic signed [CX_W-1:0]  x_r [STAGES+1];
  logic signed [CX_W-1:0]  y_r [STAGES+1];
  logic signed [ANG_W-1:0] z_r [STAGES+1];
  logic                    zero_r [STAGES+1];

  // fold the left half plane onto the right one
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (xi == '0) && (yi == '0);
      if (xi[CIN_W-1]) begin
        z_r[0] <= yi[CIN_W-1] ? -PI_Q24 : PI_Q24;
        x_r[0] <= -({{(CX_W-CIN_W-16){xi[CIN_W-1]}}, xi, 16'h0000});
        y_r[0] <= -({{(CX_W-CIN_W-16){yi[CIN_W-1]}}, yi, 16'h0000});
      end else begin
        z_r[0] <= '0;
        x_r[0] <= {{(CX_W-CIN_W-16){xi[CIN_W-1]}}, xi, 16'h0000};
        y_r[0] <= {{(CX_W-CIN_W-16){yi[CIN_W-1]}}, yi, 16'h0000};
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (!y_r[i][CX_W-1]) begin
          x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] + ATAN_Q24[i];
        end else begin
          x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
          y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
          z_r[i+1] <= z_r[i] - ATAN_Q24[i];
        end
      end
    end
  end

  assign ang = zero_r[STAGES] ? '0 : z_r[STAGES];

endmodule

FILE: design/tvac_div.sv
// pipelined angle over aperture ratio, saturated to q1.15
module tvac_div import tvac_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] ang,
  input  logic [16:0]             dvs,
  output logic signed [15:0]      ratio
);

  localparam int NW = ANG_W + 7;

  logic [NW-1:0]    rem_r [DIV_Q+1];
  logic [DIV_Q-1:0] q_r   [DIV_Q+1];
  logic             neg_r [DIV_Q+1];
  logic             zero_r [DIV_Q+1];
  logic             ovf_r [DIV_Q+1];
  logic [ANG_W-1:0] mag;
  logic [NW-1:0]    num;
  logic [15:0]      qs;
  logic [15:0]      res_r;

  always_comb begin
    mag = ang[ANG_W-1] ? ANG_W'(-ang) : ANG_W'(ang);
    num = {mag, 7'b0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_r[0]  <= ang[ANG_W-1];
      zero_r[0] <= (ang == '0);
      ovf_r[0]  <= num >= NW'({dvs, 16'h0000});
      rem_r[0]  <= num;
      q_r[0]    <= '0;
    end
  end

  for (genvar j = 0; j < DIV_Q; j++) begin : g_step
    localparam int SH = DIV_Q - 1 - j;
    logic [NW-1:0] dsh;
    logic          ge;

    always_comb begin
      dsh = NW'({dvs, {SH{1'b0}}});
      ge  = rem_r[j] >= dsh;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        neg_r[j+1]  <= neg_r[j];
        zero_r[j+1] <= zero_r[j];
        ovf_r[j+1]  <= ovf_r[j];
        rem_r[j+1]  <= ge ? rem_r[j] - dsh : rem_r[j];
        q_r[j+1]    <= q_r[j] | (ge ? DIV_Q'(1) << SH : '0);
      end
    end
  end

  always_comb begin
    if (ovf_r[DIV_Q] || (q_r[DIV_Q] > GIMBAL_SAT)) begin
      qs = GIMBAL_SAT;
    end else begin
      qs = q_r[DIV_Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (zero_r[DIV_Q]) begin
        res_r <= '0;
      end else begin
        res_r <= neg_r[DIV_Q] ? 16'(-qs) : qs;
      end
    end
  end

  assign ratio = $signed(res_r);

endmodule

FILE: verif/tb.sv
// self-checking testbench for the thrust vector to actuator command pipeline
module tb import tvac_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0]        throttle;
    logic signed [15:0] axis0;
    logic signed [15:0] axis1;
    logic               sat;
  } cmd_t;

  class cmd_scoreboard;
    logic [22:0] lim;
    logic [15:0] tscale;
    logic [16:0] maxdef;
    cmd_t pending[$];
    int errors;

    function new();
      lim = THRUST_LIMIT_RST;
      tscale = THROTTLE_SCALE_RST;
      maxdef = MAX_DEFLECTION_RST;
      errors = 0;
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned res, b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // vectoring rotation, result in q.24 radians
    function longint angle(longint y, longint x);
      longint z, xs, ys;
      z = 0;
      if (x == 0 && y == 0) return 0;
      if (x < 0) begin
        z = (y >= 0) ? PI_Q24 : -PI_Q24;
        x = -x;
        y = -y;
      end
      x = x * 65536;
      y = y * 65536;
      for (int i = 0; i < CORDIC_STAGES_DEF; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x += ys; y -= xs; z += ATAN_Q24[i];
        end else begin
          x -= ys; y += xs; z -= ATAN_Q24[i];
        end
      end
      return z;
    endfunction

    function logic signed [15:0] deflection(longint ang);
      longint unsigned m, q;
      if (ang == 0) return 0;
      m = ang < 0 ? -ang : ang;
      q = (maxdef == 0) ? GIMBAL_SAT : (m << 7) / maxdef;
      if (q > GIMBAL_SAT) q = GIMBAL_SAT;
      return ang < 0 ? -q : q;
    endfunction

    function void note_request(longint x, longint y, longint z);
      cmd_t c;
      longint unsigned sumsq, mag, s, thr, m2, x2, cc;
      sumsq = x*x + y*y + z*z;
      c.sat = sumsq > longint'(lim) * lim;
      mag = c.sat ? lim : root(sumsq);
      s = root(mag << 16);
      thr = (s * tscale) >> 17;
      c.throttle = thr > 16'hFFFF ? 16'hFFFF : thr;
      c.axis0 = deflection(angle(-y, z));
      if (mag == 0) c.axis1 = 0;
      else begin
        m2 = mag * mag;
        x2 = x * x;
        cc = m2 > x2 ? root(m2 - x2) : 0;
        c.axis1 = deflection(angle(x, cc));
      end
      pending.push_back(c);
    endfunction

    function void check_result(cmd_t got);
      cmd_t e;
      if (pending.size() == 0) begin
        $error("unexpected result");
        errors++;
        return;
      end
      e = pending.pop_front();
      if (got.throttle !== e.throttle) begin
        $error("throttle exp %0d got %0d", e.throttle, got.throttle); errors++;
      end
      if (got.axis0 !== e.axis0) begin
        $error("gimbal_axis0 exp %0d got %0d", e.axis0, got.axis0); errors++;
      end
      if (got.axis1 !== e.axis1) begin
        $error("gimbal_axis1 exp %0d got %0d", e.axis1, got.axis1); errors++;
      end
      if (got.sat !== e.sat) begin
        $error("thrust_saturated exp %0d got %0d", e.sat, got.sat); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic in_valid = 0, in_stall;
  logic signed [23:0] in_thrust_x = 0, in_thrust_y = 0, in_thrust_z = 0;
  logic out_valid, out_stall = 0;
  logic [15:0] out_throttle;
  logic signed [15:0] out_gimbal_axis0, out_gimbal_axis1;
  logic out_thrust_saturated;
  logic cfg_we = 0;
  logic [1:0] cfg_index = 0;
  logic [22:0] cfg_data = 0;

  cmd_scoreboard board = new();
  bit quiet = 0;
  bit hold_go = 0;
  bit long_hold = 0;
  int hold_cycles = 0;
  longint cycles = 0;

  thrust_vector_to_actuator_cmds_top DUT (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 400000) begin
      $display("thrust_vector_to_actuator_cmds_top: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_result({out_throttle, out_gimbal_axis0, out_gimbal_axis1,
                          out_thrust_saturated});
  end

  // long receiver hold-off, counted in its own process
  initial begin
    wait (hold_go);
    @(posedge clk);
    long_hold <= 1;
    repeat (300) @(posedge clk);
    long_hold <= 0;
  end

  // receiver stall: random bursts, plus the long hold-off
  always @(posedge clk) begin
    if (long_hold) begin
      out_stall <= 1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold_cycles <= $urandom_range(0, 9);
      out_stall <= 1;
    end else begin
      out_stall <= 0;
    end
  end

  task automatic send(logic signed [23:0] x, logic signed [23:0] y, logic signed [23:0] z);
    int gap;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_thrust_x <= x;
    in_thrust_y <= y;
    in_thrust_z <= z;
    do @(posedge clk); while (in_stall);
    board.note_request(x, y, z);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [22:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      CFG_THRUST_LIMIT: board.lim = val;
      CFG_THROTTLE_SCALE: board.tscale = val[15:0];
      CFG_MAX_DEFLECTION: board.maxdef = val[16:0];
      default: ;
    endcase
  endtask

  task automatic drain();
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  function automatic logic signed [23:0] pick();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return 24'sh7FFFFF;
      3: return -24'sh800000;
      default: return $signed($urandom_range(0, 2000000)) - 1000000;
    endcase
  endfunction

  task automatic random_run(int n);
    for (int i = 0; i < n; i++) send(pick(), pick(), pick());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed corners: zero vector, axis extremes, pure x, y and z, saturation
    send(0, 0, 0);
    send(24'sh7FFFFF, 24'sh7FFFFF, 24'sh7FFFFF);
    send(-24'sh800000, -24'sh800000, -24'sh800000);
    send(65536, 0, 0);
    send(-65536, 0, 0);
    send(0, 65536, 0);
    send(0, -65536, 0);
    send(0, 0, 65536);
    send(0, 0, -65536);
    send(0, 1, -65536);
    send(0, -1, -65536);
    send(1, 0, 0);
    send(500000, 600000, 700000);
    send(-24'sh800000, 0, 1);
    drain();
    // extreme registers, zero limit and zero aperture included
    write_reg(CFG_THRUST_LIMIT, 0);
    write_reg(CFG_THROTTLE_SCALE, 16'hFFFF);
    write_reg(CFG_MAX_DEFLECTION, 0);
    write_reg(2'd3, 23'h7FFFFF);
    send(0, 0, 0);
    send(100, -200, 300);
    random_run(150);
    drain();
    write_reg(CFG_THRUST_LIMIT, 23'h7FFFFF);
    write_reg(CFG_THROTTLE_SCALE, 0);
    write_reg(CFG_MAX_DEFLECTION, 17'd102944);
    random_run(300);
    drain();
    write_reg(CFG_THROTTLE_SCALE, 16'hFFFF);
    write_reg(CFG_MAX_DEFLECTION, 1);
    random_run(200);
    drain();
    write_reg(CFG_THRUST_LIMIT, THRUST_LIMIT_RST);
    write_reg(CFG_THROTTLE_SCALE, THROTTLE_SCALE_RST);
    write_reg(CFG_MAX_DEFLECTION, MAX_DEFLECTION_RST);
    // long receiver hold-off so the pipeline fills and backs up
    hold_go = 1;
    random_run(780);
    for (int i = 0; i < 400; i++) begin
      if (i == 250) quiet = 1;
      send($urandom, $urandom, $urandom);
    end
    in_valid <= 0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0)
      $display("thrust_vector_to_actuator_cmds_top: match");
    else
      $display("thrust_vector_to_actuator_cmds_top: mismatch");
    $finish;
  end
endmodule
